@@ design/afd_pkg.sv @@
// ---------------------------------------------------------------------------
// afd_pkg: shared types and constants for the floor-divide ALU
// Operation codes, item payload structs and the per-cell pipeline record.
// ---------------------------------------------------------------------------
package afd_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 4;
    localparam int SHAMT_W = 5;
    // one divider cell per quotient bit
    localparam int NUM_CELLS = DATA_W;

    localparam logic [OP_W-1:0] OP_ADD = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV = 4'd3;
    localparam logic [OP_W-1:0] OP_MOD = 4'd4;
    localparam logic [OP_W-1:0] OP_SHL = 4'd5;
    localparam logic [OP_W-1:0] OP_SAR = 4'd6;
    localparam logic [OP_W-1:0] OP_AND = 4'd7;
    localparam logic [OP_W-1:0] OP_OR  = 4'd8;
    localparam logic [OP_W-1:0] OP_XOR = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] operand_b;
        logic signed [DATA_W-1:0] operand_c;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     divide_error;
    } t_out;

    // Record carried from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] alt;   // result of a non-divide operation
        logic [DATA_W-1:0] num;   // dividend bits shifting out, quotient bits in
        logic [DATA_W-1:0] rem;   // partial remainder
        logic [DATA_W-1:0] den;   // divisor magnitude
        logic              sb;    // dividend sign
        logic              sc;    // divisor sign
        logic              dz;    // divisor is zero
    } t_cell;

endpackage

@@ design/alu_floor_divide.sv @@
// ---------------------------------------------------------------------------
// alu_floor_divide: 32-bit integer ALU with floored division
// Fully pipelined; every operation runs the same path so items stay in order.
// ---------------------------------------------------------------------------
// Accepts one item per clock unless stalled and returns one result item per
// item, in order. Every operation passes 34 register stages: one decode
// stage (adder, 32x32 multiplier, shifter, logic, operand magnitudes), a row
// of 32 divide cells that each resolve one quotient bit, and the sign/floor
// correction stage feeding the output register. The whole pipeline holds
// while a result waits on i_ready, so throughput is one item per cycle
// whenever the consumer takes results every cycle.
module alu_floor_divide (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  afd_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_ready,
    output afd_pkg::t_out o_out
);

    afd_pkg::t_cell w_cell [0:afd_pkg::NUM_CELLS];
    logic           adv;
    logic [afd_pkg::NUM_CELLS:0] w_vld;

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    afd_entry u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_cell  (w_cell[0])
    );

    for (genvar k = 0; k < afd_pkg::NUM_CELLS; k++) begin : g_cell
        afd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cell  (w_cell[k]),
            .o_cell  (w_cell[k+1])
        );
    end

    for (genvar k = 0; k <= afd_pkg::NUM_CELLS; k++) begin : g_vld
        assign w_vld[k] = w_cell[k].valid;
    end

    afd_fixup u_fixup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cell  (w_cell[afd_pkg::NUM_CELLS]),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // a stalled pipeline neither gains nor drops items
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(w_vld))
        else $error("pipeline valid bits moved during stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.divide_error |-> o_out.result == '0)
        else $error("divide error with nonzero result");

    a_err_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[afd_pkg::NUM_CELLS].valid && o_ready
        && w_cell[afd_pkg::NUM_CELLS].op != afd_pkg::OP_DIV
        && w_cell[afd_pkg::NUM_CELLS].op != afd_pkg::OP_MOD
        |=> !o_out.divide_error)
        else $error("divide error flagged on non-divide item");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cell[afd_pkg::NUM_CELLS].valid && w_cell[afd_pkg::NUM_CELLS].den != '0
        |-> w_cell[afd_pkg::NUM_CELLS].rem < w_cell[afd_pkg::NUM_CELLS].den)
        else $error("divider remainder not below divisor");
`endif

endmodule

@@ design/afd_entry.sv @@
// ---------------------------------------------------------------------------
// afd_entry: operand decode stage
// Computes the non-divide results and prepares magnitudes for the divider row.
// ---------------------------------------------------------------------------
module afd_entry (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  afd_pkg::t_in   i_in,
    output afd_pkg::t_cell o_cell
);

    afd_pkg::t_cell r_cell;
    afd_pkg::t_cell n_cell;

    logic [afd_pkg::SHAMT_W-1:0] sh;
    logic [afd_pkg::DATA_W-1:0]  ub;
    logic [afd_pkg::DATA_W-1:0]  uc;

    always_comb begin
        ub = i_in.operand_b;
        uc = i_in.operand_c;
        sh = uc[afd_pkg::SHAMT_W-1:0];

        n_cell       = '0;
        n_cell.valid = i_valid;
        n_cell.op    = i_in.operation;
        n_cell.sb    = ub[afd_pkg::DATA_W-1];
        n_cell.sc    = uc[afd_pkg::DATA_W-1];
        n_cell.dz    = (uc == '0);
        // magnitude of the most negative value still fits unsigned
        n_cell.num   = n_cell.sb ? (~ub + 1'b1) : ub;
        n_cell.den   = n_cell.sc ? (~uc + 1'b1) : uc;
        n_cell.rem   = '0;

        case (i_in.operation)
            afd_pkg::OP_ADD: n_cell.alt = ub + uc;
            afd_pkg::OP_SUB: n_cell.alt = ub - uc;
            afd_pkg::OP_MUL: n_cell.alt = ub * uc;
            afd_pkg::OP_SHL: n_cell.alt = ub << sh;
            afd_pkg::OP_SAR: n_cell.alt = $unsigned($signed(ub) >>> sh);
            afd_pkg::OP_AND: n_cell.alt = ub & uc;
            afd_pkg::OP_OR:  n_cell.alt = ub | uc;
            afd_pkg::OP_XOR: n_cell.alt = ub ^ uc;
            default:         n_cell.alt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_adv) begin
            r_cell.op  <= n_cell.op;
            r_cell.alt <= n_cell.alt;
            r_cell.num <= n_cell.num;
            r_cell.rem <= n_cell.rem;
            r_cell.den <= n_cell.den;
            r_cell.sb  <= n_cell.sb;
            r_cell.sc  <= n_cell.sc;
            r_cell.dz  <= n_cell.dz;
        end
    end

    assign o_cell = r_cell;

endmodule

@@ design/afd_div_cell.sv @@
// ---------------------------------------------------------------------------
// afd_div_cell: one restoring divide step
// Brings down the next dividend bit, trial-subtracts, shifts in a quotient bit.
// ---------------------------------------------------------------------------
module afd_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  afd_pkg::t_cell i_cell,
    output afd_pkg::t_cell o_cell
);

    afd_pkg::t_cell r_cell;
    afd_pkg::t_cell n_cell;

    logic [afd_pkg::DATA_W:0] trial;
    logic [afd_pkg::DATA_W:0] diff;

    always_comb begin
        trial  = {i_cell.rem, i_cell.num[afd_pkg::DATA_W-1]};
        diff   = trial - {1'b0, i_cell.den};
        n_cell = i_cell;
        if (!diff[afd_pkg::DATA_W]) begin
            n_cell.rem = diff[afd_pkg::DATA_W-1:0];
            n_cell.num = {i_cell.num[afd_pkg::DATA_W-2:0], 1'b1};
        end else begin
            n_cell.rem = trial[afd_pkg::DATA_W-1:0];
            n_cell.num = {i_cell.num[afd_pkg::DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_adv) begin
            r_cell.op  <= n_cell.op;
            r_cell.alt <= n_cell.alt;
            r_cell.num <= n_cell.num;
            r_cell.rem <= n_cell.rem;
            r_cell.den <= n_cell.den;
            r_cell.sb  <= n_cell.sb;
            r_cell.sc  <= n_cell.sc;
            r_cell.dz  <= n_cell.dz;
        end
    end

    assign o_cell = r_cell;

endmodule

@@ design/afd_fixup.sv @@
// ---------------------------------------------------------------------------
// afd_fixup: sign and floor correction, output register
// Turns magnitude quotient/remainder into floored results and picks the item.
// ---------------------------------------------------------------------------
module afd_fixup (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  afd_pkg::t_cell i_cell,
    output logic           o_valid,
    output afd_pkg::t_out  o_out
);

    logic                       r_valid;
    afd_pkg::t_out              r_out;
    afd_pkg::t_out              n_out;

    logic                       neg;
    logic                       adj;
    logic [afd_pkg::DATA_W-1:0] quot;
    logic [afd_pkg::DATA_W-1:0] modv;

    always_comb begin
        neg = i_cell.sb ^ i_cell.sc;
        // nonzero remainder with sign opposite the divisor: step quotient down
        adj = (i_cell.rem != '0) && neg;

        if (adj) begin
            quot = ~i_cell.num;
        end else if (neg) begin
            quot = ~i_cell.num + 1'b1;
        end else begin
            quot = i_cell.num;
        end

        if (adj) begin
            modv = i_cell.sc ? (i_cell.rem - i_cell.den) : (i_cell.den - i_cell.rem);
        end else begin
            modv = i_cell.sb ? (~i_cell.rem + 1'b1) : i_cell.rem;
        end

        n_out = '0;
        case (i_cell.op)
            afd_pkg::OP_DIV: begin
                n_out.divide_error = i_cell.dz;
                n_out.result       = i_cell.dz ? '0 : quot;
            end
            afd_pkg::OP_MOD: begin
                n_out.divide_error = i_cell.dz;
                n_out.result       = i_cell.dz ? '0 : modv;
            end
            default: begin
                n_out.result = i_cell.alt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

@@ bench/tb_alu_floor_divide.sv @@
// ---------------------------------------------------------------------------
// tb_alu_floor_divide: self-checking bench for the floor-divide ALU
// Drives directed corner items and then random items with random gaps on both
// channels; a scoreboard predicts each result and checks results in order.
// ---------------------------------------------------------------------------
module tb_alu_floor_divide;

    localparam int DATA_W  = afd_pkg::DATA_W;
    localparam int OP_W    = afd_pkg::OP_W;
    localparam int SHAMT_W = afd_pkg::SHAMT_W;

    localparam logic [OP_W-1:0] OP_CODE_MAX    = '1;
    localparam logic [OP_W-1:0] OP_CODE_UNUSED = afd_pkg::OP_XOR + 4'd1;
    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] ALL_ONES = '1;
    localparam int RANDOM_ITEMS = 1100;
    localparam int BLOCK_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 50;   // pipeline is 34 deep
    localparam int IDLE_LIMIT   = 2000;

    class floor_alu_scoreboard;
        afd_pkg::t_out expected_q[$];
        int unsigned   errors = 0;

        function afd_pkg::t_out predict(afd_pkg::t_in item);
            afd_pkg::t_out      res;
            longint             dividend;
            longint             divisor;
            longint             quo;
            longint             rem;
            logic [SHAMT_W-1:0] shamt;
            res.result       = '0;
            res.divide_error = 1'b0;
            shamt = item.operand_c[SHAMT_W-1:0];
            case (item.operation)
                afd_pkg::OP_ADD: res.result = item.operand_b + item.operand_c;
                afd_pkg::OP_SUB: res.result = item.operand_b - item.operand_c;
                afd_pkg::OP_MUL: res.result = item.operand_b * item.operand_c;
                afd_pkg::OP_DIV, afd_pkg::OP_MOD: begin
                    if (item.operand_c == '0) begin
                        res.divide_error = 1'b1;
                    end else begin
                        dividend = longint'(item.operand_b);
                        divisor  = longint'(item.operand_c);
                        quo = dividend / divisor;
                        rem = dividend % divisor;
                        // truncated -> floored: remainder follows divisor sign
                        if (rem != 0 && ((rem < 0) != (divisor < 0))) begin
                            quo = quo - 1;
                            rem = rem + divisor;
                        end
                        res.result = (item.operation == afd_pkg::OP_DIV) ?
                                     DATA_W'(quo) : DATA_W'(rem);
                    end
                end
                afd_pkg::OP_SHL: res.result = item.operand_b << shamt;
                afd_pkg::OP_SAR: res.result = $signed(item.operand_b) >>> shamt;
                afd_pkg::OP_AND: res.result = item.operand_b & item.operand_c;
                afd_pkg::OP_OR:  res.result = item.operand_b | item.operand_c;
                afd_pkg::OP_XOR: res.result = item.operand_b ^ item.operand_c;
                default: res = '0;
            endcase
            return res;
        endfunction

        function void note_input(afd_pkg::t_in item);
            expected_q.push_back(predict(item));
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(afd_pkg::t_out got);
            afd_pkg::t_out want;
            if (expected_q.size() == 0) begin
                report($sformatf("result item with nothing pending: result=%h err=%b",
                                 got.result, got.divide_error));
            end else begin
                want = expected_q.pop_front();
                if (got.result !== want.result)
                    report($sformatf("result: got %h, want %h", got.result, want.result));
                if (got.divide_error !== want.divide_error)
                    report($sformatf("divide_error: got %b, want %b",
                                     got.divide_error, want.divide_error));
            end
        endtask
    endclass

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_ready = 1'b0;
    afd_pkg::t_in  i_in    = '0;
    logic          o_ready;
    logic          o_valid;
    afd_pkg::t_out o_out;

    floor_alu_scoreboard sb = new();
    bit quiet = 1'b0;          // no gaps on either channel while set
    int idle_cycles = 0;

    alu_floor_divide dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return ALL_ONES;
            3:       return DATA_W'($urandom_range(0, 1));
            4:       return DATA_W'($signed($urandom_range(0, 64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    task send_item(afd_pkg::t_in item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= item;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(item);
    endtask

    task send_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] b,
                 logic signed [DATA_W-1:0] c);
        afd_pkg::t_in item;
        item.operation = op;
        item.operand_b = b;
        item.operand_c = c;
        send_item(item);
    endtask

    // consumer: random stalls between runs of ready
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_out);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        afd_pkg::t_in item;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // wrap-around on add, sub and mul
        send_op(afd_pkg::OP_ADD, MOST_POS, 32'sd1);
        send_op(afd_pkg::OP_SUB, MOST_NEG, 32'sd1);
        send_op(afd_pkg::OP_MUL, MOST_POS, MOST_POS);
        send_op(afd_pkg::OP_MUL, MOST_NEG, ALL_ONES);
        // floored div/mod over all sign combinations
        send_op(afd_pkg::OP_DIV, 32'sd7, 32'sd2);
        send_op(afd_pkg::OP_DIV, -32'sd7, 32'sd2);
        send_op(afd_pkg::OP_DIV, 32'sd7, -32'sd2);
        send_op(afd_pkg::OP_DIV, -32'sd7, -32'sd2);
        send_op(afd_pkg::OP_MOD, 32'sd7, 32'sd2);
        send_op(afd_pkg::OP_MOD, -32'sd7, 32'sd2);
        send_op(afd_pkg::OP_MOD, 32'sd7, -32'sd2);
        send_op(afd_pkg::OP_MOD, -32'sd7, -32'sd2);
        // divide by zero
        send_op(afd_pkg::OP_DIV, MOST_POS, '0);
        send_op(afd_pkg::OP_MOD, MOST_NEG, '0);
        // most negative over minus one
        send_op(afd_pkg::OP_DIV, MOST_NEG, ALL_ONES);
        send_op(afd_pkg::OP_MOD, MOST_NEG, ALL_ONES);
        // only the low five bits of the shift amount count
        send_op(afd_pkg::OP_SHL, ALL_ONES, 32'sd31);
        send_op(afd_pkg::OP_SHL, 32'sd1, 32'sd32);
        send_op(afd_pkg::OP_SAR, MOST_NEG, 32'sd31);
        send_op(afd_pkg::OP_SAR, MOST_POS, 32'sd33);
        send_op(afd_pkg::OP_AND, ALL_ONES, 32'h5A5A_A5A5);
        send_op(afd_pkg::OP_OR,  MOST_NEG, 32'h0F0F_0F0F);
        send_op(afd_pkg::OP_XOR, ALL_ONES, 32'h1234_5678);
        // unused codes
        send_op(OP_CODE_UNUSED, ALL_ONES, ALL_ONES);
        send_op(OP_CODE_MAX, MOST_NEG, ALL_ONES);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0) quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 4)
                item.operation = OP_W'($urandom_range(OP_CODE_UNUSED, OP_CODE_MAX));
            else
                item.operation = OP_W'($urandom_range(afd_pkg::OP_ADD, afd_pkg::OP_XOR));
            item.operand_b = pick_operand();
            item.operand_c = pick_operand();
            send_item(item);
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
